[rtl/modexp_pkg.sv]
package modexp_pkg;

    localparam int EXP_BITS  = 32;
    localparam int MOD_BITS  = 31;
    localparam int BASE_BITS = 32;

    // The shared multiplier consumes one multiplier bit per cycle.
    localparam int MUL_STEPS = BASE_BITS;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int EXP_CNT_W = $clog2(EXP_BITS);

    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

endpackage

[rtl/modular_exponentiation.sv]
// Channel       | Direction | Signals                          | Handshake
// --------------+-----------+----------------------------------+---------------------------
// request       | in        | i_base, i_exponent               | start & !busy
// result        | out       | o_power                          | o_power_valid, one cycle
// configuration | in        | i_cfg_wdata                      | i_cfg_we
//
// Each transaction is handled alone. The base is first reduced modulo the modulus,
// then every one of the 32 exponent bits costs a modular square and, for a set bit,
// a modular multiply. Every modular operation runs on the single bit-serial
// multiplier, one after another. A zero exponent, or a modulus below two, is answered
// without the multiplier, in the cycle after start is accepted.
// Reset is synchronous and active low and restores the modulus to 1000000007.
// The receiver cannot stall: the result is shown for exactly one cycle.
module modular_exponentiation (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [modexp_pkg::BASE_BITS-1:0]   i_base,
    input  logic [modexp_pkg::EXP_BITS-1:0]    i_exponent,
    output logic                               o_power_valid,
    output logic [modexp_pkg::MOD_BITS-1:0]    o_power,
    input  logic                               i_cfg_we,
    input  logic [modexp_pkg::MOD_BITS-1:0]    i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_SQUARE,
        S_MULT
    } t_state;

    t_state                             r_state;
    logic [modexp_pkg::MOD_BITS-1:0]    r_modulus;
    logic [modexp_pkg::BASE_BITS-1:0]   r_base_in;
    logic [modexp_pkg::MOD_BITS-1:0]    r_base;
    logic [modexp_pkg::EXP_BITS-1:0]    r_exp;
    logic [modexp_pkg::EXP_CNT_W-1:0]   r_bit;
    logic [modexp_pkg::MOD_BITS-1:0]    r_acc;
    logic                               r_go;
    logic                               r_valid;
    logic [modexp_pkg::MOD_BITS-1:0]    r_power;

    logic [modexp_pkg::BASE_BITS-1:0]   mm_x;
    logic [modexp_pkg::MOD_BITS-1:0]    mm_y;
    logic                               mm_done;
    logic [modexp_pkg::MOD_BITS-1:0]    mm_p;
    logic                               accept;

    assign accept = start && (r_state == S_IDLE);

    // The multiplier operands follow the step in hand. Reducing the base is a
    // multiply by one, which needs the modulus to be at least two.
    always_comb begin
        unique case (r_state)
            S_REDUCE: begin
                mm_x = r_base_in;
                mm_y = modexp_pkg::MOD_BITS'(1);
            end
            S_SQUARE: begin
                mm_x = modexp_pkg::BASE_BITS'(r_acc);
                mm_y = r_acc;
            end
            S_MULT: begin
                mm_x = modexp_pkg::BASE_BITS'(r_acc);
                mm_y = r_base;
            end
            default: begin
                mm_x = r_base_in;
                mm_y = r_acc;
            end
        endcase
    end

    modexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_x     (mm_x),
        .i_y     (mm_y),
        .i_m     (r_modulus),
        .o_done  (mm_done),
        .o_p     (mm_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_modulus <= modexp_pkg::MODULUS_RESET;
            r_go      <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_go    <= 1'b0;
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_base_in <= i_base;
                        r_exp     <= i_exponent;
                        r_bit     <= modexp_pkg::EXP_CNT_W'(modexp_pkg::EXP_BITS - 1);
                        r_acc     <= modexp_pkg::MOD_BITS'(1);
                        if (i_exponent == '0) begin
                            // A zero exponent gives one whatever the modulus.
                            r_valid <= 1'b1;
                            r_power <= modexp_pkg::MOD_BITS'(1);
                        end else if (r_modulus[modexp_pkg::MOD_BITS-1:1] == '0) begin
                            // A modulus of zero or one reduces everything to zero.
                            r_valid <= 1'b1;
                            r_power <= '0;
                        end else begin
                            r_state <= S_REDUCE;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_REDUCE: begin
                    if (mm_done) begin
                        r_base  <= mm_p;
                        r_state <= S_SQUARE;
                        r_go    <= 1'b1;
                    end
                end
                S_SQUARE: begin
                    if (mm_done) begin
                        r_acc <= mm_p;
                        if (r_exp[modexp_pkg::EXP_BITS-1]) begin
                            r_state <= S_MULT;
                            r_go    <= 1'b1;
                        end else if (r_bit == '0) begin
                            r_state <= S_IDLE;
                            r_valid <= 1'b1;
                            r_power <= mm_p;
                        end else begin
                            r_bit <= r_bit - 1'b1;
                            r_exp <= {r_exp[modexp_pkg::EXP_BITS-2:0], 1'b0};
                            r_go  <= 1'b1;
                        end
                    end
                end
                S_MULT: begin
                    if (mm_done) begin
                        r_acc <= mm_p;
                        if (r_bit == '0) begin
                            r_state <= S_IDLE;
                            r_valid <= 1'b1;
                            r_power <= mm_p;
                        end else begin
                            r_bit   <= r_bit - 1'b1;
                            r_exp   <= {r_exp[modexp_pkg::EXP_BITS-2:0], 1'b0};
                            r_state <= S_SQUARE;
                            r_go    <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_power_valid = r_valid;
    assign o_power       = r_power;

endmodule

[rtl/modexp_mulmod.sv]
// Bit-serial modular multiplier: p = (x * y) mod m, with y < m.
module modexp_mulmod (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [modexp_pkg::BASE_BITS-1:0]   i_x,
    input  logic [modexp_pkg::MOD_BITS-1:0]    i_y,
    input  logic [modexp_pkg::MOD_BITS-1:0]    i_m,
    output logic                               o_done,
    output logic [modexp_pkg::MOD_BITS-1:0]    o_p
);

    logic                               r_busy;
    logic [modexp_pkg::MUL_CNT_W-1:0]   r_cnt;
    logic [modexp_pkg::BASE_BITS-1:0]   r_x;
    logic [modexp_pkg::MOD_BITS-1:0]    r_y;
    logic [modexp_pkg::MOD_BITS-1:0]    r_acc;
    logic                               r_done;

    logic [modexp_pkg::MOD_BITS:0]      dbl;
    logic [modexp_pkg::MOD_BITS-1:0]    dbl_red;
    logic [modexp_pkg::MOD_BITS:0]      sum;
    logic [modexp_pkg::MOD_BITS-1:0]    n_acc;

    // Horner step: acc = 2*acc + bit*y, brought back below m after each add.
    always_comb begin
        dbl = {r_acc, 1'b0};
        if (dbl >= {1'b0, i_m}) begin
            dbl_red = modexp_pkg::MOD_BITS'(dbl - {1'b0, i_m});
        end else begin
            dbl_red = dbl[modexp_pkg::MOD_BITS-1:0];
        end
        sum = {1'b0, dbl_red} + (r_x[modexp_pkg::BASE_BITS-1] ? {1'b0, r_y} : '0);
        if (sum >= {1'b0, i_m}) begin
            n_acc = modexp_pkg::MOD_BITS'(sum - {1'b0, i_m});
        end else begin
            n_acc = sum[modexp_pkg::MOD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_acc <= n_acc;
                r_x   <= {r_x[modexp_pkg::BASE_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= modexp_pkg::MUL_CNT_W'(modexp_pkg::MUL_STEPS - 1);
                r_x    <= i_x;
                r_y    <= i_y;
                r_acc  <= '0;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule
